// ----- sv/nns_pkg.sv -----
// shared constants and types for the nearest neighbour search block
`default_nettype none

package nns_pkg;

    // storage and geometry
    localparam int POINTS     = 1024;
    localparam int DIMS       = 3;
    localparam int ADDR_W     = $clog2(POINTS);
    localparam int CNT_W      = $clog2(POINTS + 1);

    // field widths
    localparam int INDEX_W    = 10;
    localparam int COORD_W    = 24;
    localparam int KEY_W      = 32;
    localparam int ID_W       = 32;
    localparam int DIST_W     = 26;
    localparam int PCOUNT_W   = 11;

    // distance arithmetic
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = SUM_W / 2;

    // stream widths
    localparam int S_TDATA_W  = 120;
    localparam int M_TDATA_W  = 168;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = PCOUNT_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_POINT_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_USE_KEY     = 1'b1;

    // item kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } point_t;

    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] slot;
        logic [SUM_W-1:0]  dist_sq;
    } cand_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

`default_nettype wire

// ----- sv/nns_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module nns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/nns_dist.sv -----
// squared distance pipeline: difference, square, sum
`default_nettype none

module nns_dist
    import nns_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_vld,
    input  wire logic [ADDR_W-1:0] in_slot,
    input  wire point_t            cand_pt,
    input  wire point_t            self_pt,
    output cand_t                  cand
);

    coord_t cand_c [3];
    coord_t self_c [3];

    logic                     a_vld_reg;
    logic [ADDR_W-1:0]        a_slot_reg;
    logic signed [DIFF_W-1:0] diff_reg [DIMS];

    logic                     b_vld_reg;
    logic [ADDR_W-1:0]        b_slot_reg;
    logic [SQ_W-1:0]          sq_reg [DIMS];

    logic [SUM_W-1:0]         sum;
    cand_t                    cand_reg;

    assign cand_c[0] = cand_pt.x;
    assign cand_c[1] = cand_pt.y;
    assign cand_c[2] = cand_pt.z;
    assign self_c[0] = self_pt.x;
    assign self_c[1] = self_pt.y;
    assign self_c[2] = self_pt.z;

    // valid and slot tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            a_slot_reg <= '0;
            b_vld_reg  <= 1'b0;
            b_slot_reg <= '0;
            cand_reg   <= '0;
        end
        else
        begin
            a_vld_reg        <= in_vld;
            a_slot_reg       <= in_slot;
            b_vld_reg        <= a_vld_reg;
            b_slot_reg       <= a_slot_reg;
            cand_reg.vld     <= b_vld_reg;
            cand_reg.slot    <= b_slot_reg;
            cand_reg.dist_sq <= sum;
        end
    end

    // per-axis difference, then square
    always_ff @(posedge clk)
    begin
        for (int d = 0; d < DIMS; d++)
        begin
            diff_reg[d] <= DIFF_W'(cand_c[d]) - DIFF_W'(self_c[d]);
            sq_reg[d]   <= SQ_W'(diff_reg[d] * diff_reg[d]);
        end
    end

    always_comb
    begin
        sum = '0;
        for (int d = 0; d < DIMS; d++)
        begin
            sum = sum + SUM_W'(sq_reg[d]);
        end
    end

    assign cand = cand_reg;

endmodule

`default_nettype wire

// ----- sv/nns_sqrt.sv -----
// bit-serial integer square root, one result bit per cycle
`default_nettype none

module nns_sqrt
    import nns_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] value,
    output sqrt_stat_t            stat,
    output logic [ROOT_W-1:0]     root
);

    localparam int ITER_W = $clog2(ROOT_W + 1);

    logic [SUM_W-1:0]    val_reg;
    logic [ROOT_W:0]     rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [ROOT_W+2:0]   rem_sh;
    logic [ROOT_W+2:0]   trial;
    logic                fits;

    assign rem_sh = {rem_reg, val_reg[SUM_W-1 -: 2]};
    assign trial  = (ROOT_W + 3)'({root_reg, 2'b01});
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                val_reg  <= value;
                rem_reg  <= '0;
                root_reg <= '0;
                iter_reg <= ITER_W'(ROOT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                val_reg  <= val_reg << 2;
                rem_reg  <= fits ? (ROOT_W + 1)'(rem_sh - trial) : (ROOT_W + 1)'(rem_sh);
                root_reg <= {root_reg[ROOT_W-2:0], fits};
                iter_reg <= iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

`default_nettype wire

// ----- sv/nearest_neighbour_search_core.sv -----
// top level of the brute-force nearest neighbour search block
//
// input stream (s_*): one transfer per item. s_tuser selects the kind: a write
// stores a point and key in the slot given by index and gives no result; a
// query names a slot and gives exactly one result on the output stream (m_*).
// configuration: cfg_we with cfg_addr 0 sets point_count, 1 sets use_key;
// write only while no query is in flight.
// a query reads its own point, scans slots 0..point_count-1 (point_count
// capped at the store depth) through the coordinate ram, one slot per cycle,
// then waits for the distance pipeline to drain, fetches the neighbour key and
// runs a bit-serial 25-step square root before the result reaches the output
// register; one query is worked on at a time.
// results sit in an output register: a new item is taken while a result
// waits, but a finished query holds in its last state until m_tready frees
// the register.
// reset clears control state and sets point_count to 1 and use_key to 0. the
// point stores are not cleared: a slot that was never written reads garbage.
`default_nettype none

module nearest_neighbour_search_core
    import nns_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // index[9:0], pos_x[33:10], pos_y[57:34], pos_z[81:58], point_key[113:82]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  wire logic                  s_tuser,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // self_id[31:0], neighbour_id[63:32], nearest_distance[89:64],
    // self_x[113:90], self_y[137:114], self_z[161:138]
    output logic [M_TDATA_W-1:0]       m_tdata,
    // found[0]
    output logic                       m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int OUT_PAD_W = M_TDATA_W - (2 * ID_W + DIST_W + 3 * COORD_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SELF,
        S_SCAN,
        S_DRAIN,
        S_KEY,
        S_SQRT,
        S_OUT
    } state_t;

    state_t               state_reg;

    // configuration
    logic [PCOUNT_W-1:0]  pc_reg;
    logic                 use_key_reg;

    // input unpacking
    logic [INDEX_W-1:0]   in_index;
    point_t               in_point;
    logic [KEY_W-1:0]     in_key;
    logic                 in_op;
    logic                 in_range;
    logic                 accept;
    logic                 wr_en;

    // query context
    logic [INDEX_W-1:0]   self_idx_reg;
    logic                 self_in_reg;
    point_t               self_pt_reg;
    logic [KEY_W-1:0]     self_key_reg;

    // scan control
    logic [CNT_W-1:0]     cnt;
    logic [CNT_W-1:0]     j_reg;
    logic                 rv_reg;
    logic [ADDR_W-1:0]    rslot_reg;
    logic [1:0]           drain_reg;

    // ram access
    logic [ADDR_W-1:0]    rd_addr;
    point_t               pt_rd;
    logic [KEY_W-1:0]     key_rd;

    // running minimum
    cand_t                cand;
    logic                 found_reg;
    logic [SUM_W-1:0]     best_d_reg;
    logic [ADDR_W-1:0]    best_slot_reg;

    // root and output
    sqrt_stat_t           sq_stat;
    logic [ROOT_W-1:0]    sq_root;
    logic                 out_load;
    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [ID_W-1:0]      self_id;
    logic [ID_W-1:0]      nb_id;
    logic [DIST_W-1:0]    nb_dist;

    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_point.x = s_tdata[INDEX_W +: COORD_W];
    assign in_point.y = s_tdata[INDEX_W + COORD_W +: COORD_W];
    assign in_point.z = s_tdata[INDEX_W + 2 * COORD_W +: COORD_W];
    assign in_key   = s_tdata[INDEX_W + 3 * COORD_W +: KEY_W];
    assign in_op    = s_tuser;
    assign in_range = (int'(in_index) < POINTS);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    // slots beyond storage drop the write
    assign wr_en    = accept && (in_op == OP_WRITE) && in_range;

    // count saturates at the store depth
    assign cnt = (int'(pc_reg) > POINTS) ? CNT_W'(POINTS) : CNT_W'(pc_reg);

    always_comb
    begin
        unique case (state_reg) inside
            S_IDLE:                rd_addr = ADDR_W'(in_index);
            S_KEY, S_SQRT, S_OUT:  rd_addr = best_slot_reg;
            default:               rd_addr = j_reg[ADDR_W-1:0];
        endcase
    end

    nns_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (POINTS)
    ) u_coord_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ADDR_W'(in_index)),
        .wdata (in_point),
        .raddr (rd_addr),
        .rdata (pt_rd)
    );

    nns_ram #(
        .WIDTH (KEY_W),
        .DEPTH (POINTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ADDR_W'(in_index)),
        .wdata (in_key),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    nns_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (rv_reg),
        .in_slot (rslot_reg),
        .cand_pt (pt_rd),
        .self_pt (self_pt_reg),
        .cand    (cand)
    );

    nns_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_KEY),
        .value (best_d_reg),
        .stat  (sq_stat),
        .root  (sq_root)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= PCOUNT_W'(1);
            use_key_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_POINT_COUNT: pc_reg      <= cfg_wdata[PCOUNT_W-1:0];
                CFG_USE_KEY:     use_key_reg <= cfg_wdata[0];
                default:         pc_reg      <= pc_reg;
            endcase
        end
    end

    // running minimum; strict less-than keeps the lowest slot on a tie
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            best_d_reg    <= '0;
            best_slot_reg <= '0;
        end
        else if (accept && (in_op == OP_QUERY))
        begin
            found_reg     <= 1'b0;
            best_d_reg    <= '0;
            best_slot_reg <= '0;
        end
        else if (cand.vld && (!found_reg || (cand.dist_sq < best_d_reg)))
        begin
            found_reg     <= 1'b1;
            best_d_reg    <= cand.dist_sq;
            best_slot_reg <= cand.slot;
        end
    end

    // result fields
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);
    assign self_id  = use_key_reg ? self_key_reg : ID_W'(self_idx_reg);
    assign nb_id    = !found_reg ? '0 : (use_key_reg ? key_rd : ID_W'(best_slot_reg));
    assign nb_dist  = found_reg ? DIST_W'(sq_root) : '0;

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            self_idx_reg  <= '0;
            self_in_reg   <= 1'b0;
            self_pt_reg   <= '0;
            self_key_reg  <= '0;
            j_reg         <= '0;
            rv_reg        <= 1'b0;
            rslot_reg     <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            rv_reg <= 1'b0;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_found_reg <= found_reg;
                out_data_reg  <= {{OUT_PAD_W{1'b0}}, self_pt_reg.z, self_pt_reg.y,
                                  self_pt_reg.x, nb_dist, nb_id, self_id};
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (in_op == OP_QUERY))
                    begin
                        self_idx_reg <= in_index;
                        self_in_reg  <= in_range;
                        state_reg    <= S_SELF;
                    end
                end
                S_SELF:
                begin
                    // a slot beyond storage reads as the origin with key zero
                    self_pt_reg  <= self_in_reg ? pt_rd : '0;
                    self_key_reg <= self_in_reg ? key_rd : '0;
                    j_reg        <= '0;
                    drain_reg    <= '0;
                    state_reg    <= (cnt == '0) ? S_DRAIN : S_SCAN;
                end
                S_SCAN:
                begin
                    rv_reg    <= !(self_in_reg &&
                                   (j_reg[ADDR_W-1:0] == ADDR_W'(self_idx_reg)));
                    rslot_reg <= j_reg[ADDR_W-1:0];
                    j_reg     <= j_reg + CNT_W'(1);
                    if (j_reg == (cnt - CNT_W'(1)))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    // ram read plus three distance stages
                    drain_reg <= drain_reg + 2'd1;
                    if (drain_reg == 2'd3)
                    begin
                        state_reg <= S_KEY;
                    end
                end
                S_KEY:
                begin
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sq_stat.done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_data_reg;

    // candidates only arrive while a scan is running or draining
    assert property (@(posedge clk) disable iff (!rst_n)
        cand.vld |-> ((state_reg == S_SCAN) || (state_reg == S_DRAIN)))
        else $error("candidate outside scan");

    // the queried slot never competes with itself
    assert property (@(posedge clk) disable iff (!rst_n)
        (cand.vld && self_in_reg) |-> (cand.slot != ADDR_W'(self_idx_reg)))
        else $error("queried slot entered the search");

    // the root finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.done |-> (state_reg == S_SQRT))
        else $error("root done out of sequence");

    // root unit is free whenever a new root is started
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_KEY) |-> !sq_stat.busy)
        else $error("root started while busy");

    // a query blocks further transfers in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == OP_QUERY)) |=> !s_tready)
        else $error("input taken during a query");

endmodule

`default_nettype wire

// ----- dv/nns_scoreboard_pkg.sv -----
// scoreboard for the nearest neighbour search block, with its own search predictor
`timescale 1ns / 100ps

package nns_scoreboard_pkg;

    import nns_pkg::*;

    // one result as it leaves the block
    typedef struct {
        logic [ID_W-1:0]   self_id;
        logic [ID_W-1:0]   neighbour_id;
        logic              found;
        logic [DIST_W-1:0] distance;
        coord_t            x;
        coord_t            y;
        coord_t            z;
    } answer_t;

    class neighbour_scoreboard;

        coord_t           x_mem   [POINTS];
        coord_t           y_mem   [POINTS];
        coord_t           z_mem   [POINTS];
        logic [KEY_W-1:0] key_mem [POINTS];
        int unsigned      scan_limit;
        bit               report_keys;
        answer_t          answers [$];
        int unsigned      failures;

        function new();
            scan_limit  = 1;
            report_keys = 1'b0;
            failures    = 0;
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] addr,
                                   logic [CFG_DATA_W-1:0] value);
            if (addr == CFG_POINT_COUNT)
                scan_limit = value;
            else
                report_keys = value[0];
        endfunction

        function longint unsigned gap_sq(coord_t a, coord_t b);
            longint d;
            d = longint'(a) - longint'(b);
            return d * d;
        endfunction

        // bitwise search for the largest root whose square still fits
        function logic [DIST_W-1:0] root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = DIST_W - 1; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r[DIST_W-1:0];
        endfunction

        function answer_t search_from(logic [INDEX_W-1:0] slot);
            answer_t         a;
            int unsigned     limit;
            int unsigned     best;
            longint unsigned dist_sq;
            longint unsigned best_dist;
            bit              hit;
            limit     = (scan_limit > POINTS) ? POINTS : scan_limit;
            best      = 0;
            best_dist = 0;
            hit       = 1'b0;
            for (int unsigned j = 0; j < limit; j++)
            begin
                if (j != slot)
                begin
                    dist_sq = gap_sq(x_mem[slot], x_mem[j]);
                    if (DIMS >= 2)
                        dist_sq += gap_sq(y_mem[slot], y_mem[j]);
                    if (DIMS >= 3)
                        dist_sq += gap_sq(z_mem[slot], z_mem[j]);
                    // strict compare keeps the lowest slot on a tie
                    if (!hit || dist_sq < best_dist)
                    begin
                        best      = j;
                        best_dist = dist_sq;
                        hit       = 1'b1;
                    end
                end
            end
            a.self_id      = report_keys ? key_mem[slot] : {{(ID_W-INDEX_W){1'b0}}, slot};
            a.neighbour_id = !hit ? '0 : (report_keys ? key_mem[best] : best);
            a.found        = hit;
            a.distance     = hit ? root_floor(best_dist) : '0;
            a.x            = x_mem[slot];
            a.y            = y_mem[slot];
            a.z            = z_mem[slot];
            return a;
        endfunction

        function void note_item(logic op, logic [INDEX_W-1:0] slot, point_t p,
                                logic [KEY_W-1:0] key);
            if (op == OP_WRITE)
            begin
                x_mem[slot]   = p.x;
                y_mem[slot]   = p.y;
                z_mem[slot]   = p.z;
                key_mem[slot] = key;
            end
            else
                answers.push_back(search_from(slot));
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
                failures++;
            end
        endfunction

        function void check_result(answer_t got);
            answer_t want;
            if (answers.size() == 0)
            begin
                $display("%0t: result with no query waiting, expected none, actual self_id %0h",
                         $time, got.self_id);
                failures++;
                return;
            end
            want = answers.pop_front();
            compare("self_id", want.self_id, got.self_id);
            compare("neighbour_id", want.neighbour_id, got.neighbour_id);
            compare("found", want.found, got.found);
            compare("nearest_distance", want.distance, got.distance);
            compare("self_x", want.x, got.x);
            compare("self_y", want.y, got.y);
            compare("self_z", want.z, got.z);
        endfunction

    endclass

endpackage

// ----- dv/tb.sv -----
// testbench top for the nearest neighbour search core
`timescale 1ns / 100ps

module tb;

    import nns_pkg::*;
    import nns_scoreboard_pkg::*;

    // random part length, and the quiet time after the last result
    localparam int unsigned RANDOM_ITEMS  = 450;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned DRAIN_CYCLES  = POINTS + 80;
    localparam int unsigned HOLD_CYCLES   = 3000;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    neighbour_scoreboard sb = new();

    // stimulus side bookkeeping: which slots hold a point, and what the point is,
    // so queries never touch a slot that was never written
    bit          slot_loaded  [POINTS];
    point_t      layout       [POINTS];
    int unsigned loaded_slots [$];
    int unsigned items_sent  = 0;

    // idling knobs, switched per phase
    bit          source_gaps = 1'b1;
    bit          sink_stalls = 1'b1;
    int unsigned sink_hold   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    nearest_neighbour_search_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge, before the
    // nonblocking updates of that edge land
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        answer_t seen;
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_register(cfg_addr, cfg_wdata);
            // input transfer: index[9:0], point {z,y,x}[81:10], key[113:82]
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata[9:0], s_tdata[81:10], s_tdata[113:82]);
            // output transfer, unpacked field by field
            if (m_tvalid && m_tready)
            begin
                seen.self_id      = m_tdata[31:0];
                seen.neighbour_id = m_tdata[63:32];
                seen.distance     = m_tdata[89:64];
                seen.x            = m_tdata[113:90];
                seen.y            = m_tdata[137:114];
                seen.z            = m_tdata[161:138];
                seen.found        = m_tuser;
                sb.check_result(seen);
            end
        end
    end

    // ------------------------------------------------------------------
    // result sink: random stall before each transfer, and one long
    // hold-off when the stimulus asks for it
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold != 0)
            begin
                stall     = sink_hold;
                sink_hold = 0;
            end
            else
                stall = sink_stalls ? $urandom_range(0, 15) : 0;
            // only lower ready when a stall really happens, so it is never
            // dropped and raised within one step
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // point generation
    // ------------------------------------------------------------------
    function automatic point_t pt(coord_t x, coord_t y, coord_t z);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        return p;
    endfunction

    function automatic coord_t corner();
        case ($urandom_range(0, 3))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // offset around a value, wrapping at the coordinate width
    function automatic coord_t jitter(coord_t c, int unsigned span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - int'(span) + int'(c);
        return v[COORD_W-1:0];
    endfunction

    // mix of full-range points, points near the origin, near or on top of
    // an existing point (close races and ties), and cube corners
    function automatic point_t random_point();
        point_t      p;
        point_t      base;
        logic [31:0] r;
        if (loaded_slots.size() == 0)
            base = '0;
        else
            base = layout[loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]];
        case ($urandom_range(0, 9)) inside
            4, 5:
                p = pt(jitter(coord_t'(0), 64), jitter(coord_t'(0), 64),
                       jitter(coord_t'(0), 64));
            6, 7:
                p = pt(jitter(base.x, 16), jitter(base.y, 16), jitter(base.z, 16));
            8:
                p = base;
            9:
                p = pt(corner(), corner(), corner());
            default:
            begin
                r   = $urandom;
                p.x = r[COORD_W-1:0];
                r   = $urandom;
                p.y = r[COORD_W-1:0];
                r   = $urandom;
                p.z = r[COORD_W-1:0];
            end
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one input transfer; valid stays high into the next item unless
    // that item draws a gap
    task automatic send_item(input logic op, input int unsigned slot, input point_t p,
                             input logic [KEY_W-1:0] key);
        int unsigned        gap;
        logic [INDEX_W-1:0] idx;
        idx = slot[INDEX_W-1:0];
        gap = source_gaps ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W-114){1'b0}}, key, p, idx};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic put_point(input int unsigned slot, input point_t p,
                             input logic [KEY_W-1:0] key);
        send_item(OP_WRITE, slot, p, key);
        if (!slot_loaded[slot])
        begin
            slot_loaded[slot] = 1'b1;
            loaded_slots.push_back(slot);
        end
        layout[slot] = p;
    endtask

    // coordinate and key fields of a query carry random filler
    task automatic ask(input int unsigned slot);
        send_item(OP_QUERY, slot, random_point(), $urandom);
    endtask

    // both registers, back to back with the write enable held high
    task automatic configure(input int unsigned count, input bit keys);
        logic [CFG_DATA_W-1:0] c;
        c = count[CFG_DATA_W-1:0];
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_POINT_COUNT;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_addr  <= CFG_USE_KEY;
        cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, keys};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // drop valid, let the monitor log the last transfer, wait for every
    // outstanding query, then give trailing writes time to land
    task automatic settle(input int unsigned extra);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.answers.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // directed cases
    // ------------------------------------------------------------------
    task automatic directed_cases();
        // single counted point: the query finds nothing
        configure(1, 1'b0);
        put_point(0, pt(COORD_MAX, COORD_MIN, coord_t'(0)), 32'hFFFF_FFFF);
        ask(0);
        settle(SETTLE_CYCLES);

        // count of zero, ids reported as keys
        configure(0, 1'b1);
        ask(0);
        settle(SETTLE_CYCLES);

        // opposite cube corners: largest possible distance
        configure(2, 1'b0);
        put_point(1, pt(COORD_MIN, COORD_MIN, COORD_MIN), 32'h0000_0000);
        put_point(0, pt(COORD_MAX, COORD_MAX, COORD_MAX), 32'hFFFF_FFFF);
        ask(0);
        ask(1);
        // top slot, queried from beyond the count: every counted slot competes
        put_point(POINTS - 1, pt('1, coord_t'(1), coord_t'(0)), 32'h8000_0001);
        ask(POINTS - 1);
        settle(SETTLE_CYCLES);

        // three identical points: the lowest slot wins the tie
        configure(4, 1'b1);
        put_point(2, pt(COORD_MIN, COORD_MIN, COORD_MIN), 32'h1234_5678);
        put_point(3, pt(COORD_MIN, COORD_MIN, COORD_MIN), 32'h0F0F_0F0F);
        ask(0);
        ask(3);
        ask(POINTS - 1);
        settle(SETTLE_CYCLES);

        // neighbours one lsb apart
        configure(3, 1'b0);
        put_point(2, pt(COORD_MIN + coord_t'(1), COORD_MIN, COORD_MIN), 32'h5555_AAAA);
        ask(1);
        ask(2);
    endtask

    // ------------------------------------------------------------------
    // random phase: one setting, all counted slots filled first, then a
    // mix of queries and writes; the squeeze variant holds the sink off
    // while back-to-back queries pile up behind the output register
    // ------------------------------------------------------------------
    task automatic random_phase(input int unsigned items, input bit squeeze);
        int unsigned cnt;
        int unsigned slot;
        int unsigned top;
        bit          keys;
        settle(SETTLE_CYCLES);
        case ($urandom_range(0, 19)) inside
            0:       cnt = 0;
            1:       cnt = 1;
            2, 3:    cnt = $urandom_range(25, 200);
            default: cnt = $urandom_range(2, 24);
        endcase
        if (squeeze)
            cnt = $urandom_range(2, 6);
        keys        = ($urandom_range(0, 1) == 1);
        source_gaps = squeeze ? 1'b0 : ($urandom_range(0, 3) != 0);
        sink_stalls = ($urandom_range(0, 3) != 0);
        configure(cnt, keys);

        for (int unsigned s = 0; s < cnt; s++)
            if (!slot_loaded[s])
                put_point(s, random_point(), $urandom);

        if (squeeze)
            sink_hold = HOLD_CYCLES;

        top = (cnt + 4 < POINTS) ? cnt + 4 : POINTS - 1;
        for (int unsigned n = 0; n < items; n++)
        begin
            if ($urandom_range(0, 9) < (squeeze ? 9 : 6))
            begin
                // mostly counted slots, sometimes any written slot
                if (cnt > 0 && $urandom_range(0, 4) != 0)
                    slot = $urandom_range(0, cnt - 1);
                else
                    slot = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
                ask(slot);
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                    slot = $urandom_range(0, top);
                else
                    slot = $urandom_range(0, POINTS - 1);
                put_point(slot, random_point(), $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned target;
        int unsigned phase;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= OP_WRITE;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_POINT_COUNT;
        cfg_wdata <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_cases();

        target = items_sent + RANDOM_ITEMS;
        phase  = 0;
        while (items_sent < target)
        begin
            random_phase($urandom_range(15, 40), phase == 2);
            phase++;
        end

        // nothing left in flight, then a quiet window for stray results
        settle(DRAIN_CYCLES);
        if (sb.failures == 0 && sb.answers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hard stop, well beyond the slowest legal run
    initial
    begin : watchdog
        #(8_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
